/* src/ctsgr_pkg.sv */
// shared constants, codes and queue entry type for the glyph renderer
package ctsgr_pkg;

    // screen and font geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int FONT_BYTES    = 4096;

    localparam int COL_W   = $clog2(SCREEN_WIDTH);
    localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
    localparam int FONT_AW = $clog2(FONT_BYTES);
    localparam int LIN_W   = COL_W + ROW_W;
    localparam int PIX_AW  = 16;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 13;

    localparam logic [CFG_IW-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IW-1:0] REG_INITIAL_COLOR = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GLYPH_BASE    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_FONT_SIZE     = 3'd4;

    // input operations
    localparam logic OP_FONT   = 1'b0;
    localparam logic OP_STREAM = 1'b1;

    // stream codes
    localparam logic [7:0] CODE_END     = 8'hFF;
    localparam logic [7:0] CODE_NEWLINE = 8'h0D;
    localparam logic [7:0] CODE_FIRST   = 8'h20;
    localparam int         COLOR_BIT    = 7;

    // queue entry kinds
    localparam logic CMD_FONT  = 1'b0;
    localparam logic CMD_GLYPH = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one entry between front and back
    typedef struct packed {
        logic               kind;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         data;
        logic [7:0]         color;
        logic [7:0]         col_mask;
        logic [7:0]         row_mask;
        logic [COL_W-1:0]   x_low;
        logic [ROW_W-1:0]   y_low;
    } cmd_t;

endpackage

/* src/coded_text_stream_glyph_renderer.sv */
// Text overlay renderer: a byte stream is drawn as 8x8 glyphs into pixel writes.
//
// Channels: the input channel (in_valid/in_ready) carries either a font byte
// write (operation 0) or one stream byte (operation 1). The output channel
// (out_valid/out_ready) carries one pixel write per beat: framebuffer address,
// colour and a flag on the final write caused by a stream byte. The
// configuration channel (cfg_valid/cfg_ready, always ready) writes origin,
// initial colour, glyph base and font size; write it only while the block idles.
// Throughput: the front end takes one input beat per cycle while the four-entry
// command queue has room. Font writes and visible glyphs enter the queue; the
// glyph engine performs each font write as it pops it and, per glyph, pops the
// entry, fetches eight rows through the font memory read port, and then emits
// one pixel write per set bit (at most 64), taking no new entry until it is done.
// Reset clears cursor, colour and configuration; font memory content is kept
// undefined until written. A stalled receiver holds the output register, which
// stops the glyph engine; the front end keeps accepting until the queue fills.
module coded_text_stream_glyph_renderer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ctsgr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [ctsgr_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [11:0]                   font_address,
    input  logic [7:0]                    font_byte,
    input  logic [7:0]                    stream_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   pixel_address,
    output logic [7:0]                    pixel_color,
    output logic                          last_pixel
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_not_empty;
    ctsgr_pkg::cmd_t push_cmd;
    ctsgr_pkg::cmd_t head_cmd;

    // decode and classify
    ctsgr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .font_address (font_address),
        .font_byte    (font_byte),
        .stream_byte  (stream_byte),
        .last_byte    (last_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    // command queue
    ctsgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    // glyph engine
    ctsgr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_pop         (q_pop),
        .q_cmd         (head_cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel)
    );

endmodule

/* src/ctsgr_front.sv */
// front end: configuration registers, stream decoding, cursor and clip masks
module ctsgr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ctsgr_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [ctsgr_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [11:0]                   font_address,
    input  logic [7:0]                    font_byte,
    input  logic [7:0]                    stream_byte,
    input  logic                          last_byte,
    input  logic                          q_full,
    output logic                          q_push,
    output ctsgr_pkg::cmd_t               q_cmd
);

    localparam int XW = 18;

    logic [10:0] origin_x_reg, origin_x_next;
    logic [10:0] origin_y_reg, origin_y_next;
    logic [7:0]  initial_color_reg, initial_color_next;
    logic [11:0] glyph_base_reg, glyph_base_next;
    logic [12:0] font_size_reg, font_size_next;

    logic [15:0] col_off_reg, col_off_next;
    logic [15:0] row_off_reg, row_off_next;
    logic        ovr_valid_reg, ovr_valid_next;
    logic [2:0]  ovr_color_reg, ovr_color_next;
    logic        stopped_reg, stopped_next;

    logic        accept;
    logic [12:0] bound;
    logic [10:0] goff;
    logic [13:0] start;
    logic        in_bounds;
    logic signed [XW-1:0] x0, y0, dx, dy;
    logic [7:0]  col_mask, row_mask;
    logic [7:0]  color;
    logic [15:0] col_sat, row_sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    // configuration writes
    always_comb
    begin
        origin_x_next      = origin_x_reg;
        origin_y_next      = origin_y_reg;
        initial_color_next = initial_color_reg;
        glyph_base_next    = glyph_base_reg;
        font_size_next     = font_size_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ctsgr_pkg::REG_ORIGIN_X:      origin_x_next      = cfg_data[10:0];
                ctsgr_pkg::REG_ORIGIN_Y:      origin_y_next      = cfg_data[10:0];
                ctsgr_pkg::REG_INITIAL_COLOR: initial_color_next = cfg_data[7:0];
                ctsgr_pkg::REG_GLYPH_BASE:    glyph_base_next    = cfg_data[11:0];
                ctsgr_pkg::REG_FONT_SIZE:     font_size_next     = cfg_data;
                default: ;
            endcase
        end
    end

    // glyph location and font bound check
    always_comb
    begin
        if (32'(font_size_reg) < ctsgr_pkg::FONT_BYTES)
            bound = font_size_reg;
        else
            bound = 13'(ctsgr_pkg::FONT_BYTES);
        goff      = {stream_byte - ctsgr_pkg::CODE_FIRST, 3'b000};
        start     = 14'(glyph_base_reg) + 14'(goff);
        in_bounds = (start + 14'd8) <= 14'(bound);
    end

    // screen position of the cursor and per-row / per-column clip masks
    always_comb
    begin
        x0 = $signed({{(XW-11){origin_x_reg[10]}}, origin_x_reg})
           + $signed({{(XW-16){1'b0}}, col_off_reg});
        y0 = $signed({{(XW-11){origin_y_reg[10]}}, origin_y_reg})
           + $signed({{(XW-16){1'b0}}, row_off_reg});
        dx = x0;
        dy = y0;
        for (int k = 0; k < 8; k++)
        begin
            dx = x0 + XW'(k);
            dy = y0 + XW'(k);
            col_mask[7-k] = !dx[XW-1] && (32'(dx[XW-2:0]) < ctsgr_pkg::SCREEN_WIDTH);
            row_mask[k]   = !dy[XW-1] && (32'(dy[XW-2:0]) < ctsgr_pkg::SCREEN_HEIGHT);
        end
        color   = ovr_valid_reg ? {5'b00000, ovr_color_reg} : initial_color_reg;
        col_sat = (col_off_reg >= 16'hFFF8) ? 16'hFFFF : col_off_reg + 16'd8;
        row_sat = (row_off_reg >= 16'hFFF8) ? 16'hFFFF : row_off_reg + 16'd8;
    end

    // stream decoding and queue entry
    always_comb
    begin
        col_off_next   = col_off_reg;
        row_off_next   = row_off_reg;
        ovr_valid_next = ovr_valid_reg;
        ovr_color_next = ovr_color_reg;
        stopped_next   = stopped_reg;
        q_push         = 1'b0;

        q_cmd.kind     = ctsgr_pkg::CMD_GLYPH;
        q_cmd.addr     = ctsgr_pkg::FONT_AW'(start);
        q_cmd.data     = font_byte;
        q_cmd.color    = color;
        q_cmd.col_mask = col_mask;
        q_cmd.row_mask = row_mask;
        q_cmd.x_low    = ctsgr_pkg::COL_W'(x0);
        q_cmd.y_low    = ctsgr_pkg::ROW_W'(y0);

        if (accept)
        begin
            if (operation == ctsgr_pkg::OP_FONT)
            begin
                q_cmd.kind = ctsgr_pkg::CMD_FONT;
                q_cmd.addr = ctsgr_pkg::FONT_AW'(font_address);
                q_push     = 32'(font_address) < ctsgr_pkg::FONT_BYTES;
            end
            else
            begin
                if (!stopped_reg)
                begin
                    if (stream_byte == ctsgr_pkg::CODE_END)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (stream_byte == ctsgr_pkg::CODE_NEWLINE)
                    begin
                        col_off_next = 16'd0;
                        row_off_next = row_sat;
                    end
                    else if (stream_byte[ctsgr_pkg::COLOR_BIT])
                    begin
                        ovr_color_next = stream_byte[2:0];
                        ovr_valid_next = 1'b1;
                    end
                    else
                    begin
                        q_push = (stream_byte >= ctsgr_pkg::CODE_FIRST) && in_bounds
                              && (|col_mask) && (|row_mask);
                        col_off_next = col_sat;
                    end
                end
                if (last_byte)
                begin
                    col_off_next   = 16'd0;
                    row_off_next   = 16'd0;
                    ovr_valid_next = 1'b0;
                    ovr_color_next = 3'd0;
                    stopped_next   = 1'b0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            initial_color_reg <= '0;
            glyph_base_reg    <= '0;
            font_size_reg     <= '0;
            col_off_reg       <= '0;
            row_off_reg       <= '0;
            ovr_valid_reg     <= 1'b0;
            ovr_color_reg     <= '0;
            stopped_reg       <= 1'b0;
        end
        else
        begin
            origin_x_reg      <= origin_x_next;
            origin_y_reg      <= origin_y_next;
            initial_color_reg <= initial_color_next;
            glyph_base_reg    <= glyph_base_next;
            font_size_reg     <= font_size_next;
            col_off_reg       <= col_off_next;
            row_off_reg       <= row_off_next;
            ovr_valid_reg     <= ovr_valid_next;
            ovr_color_reg     <= ovr_color_next;
            stopped_reg       <= stopped_next;
        end
    end

endmodule

/* src/ctsgr_queue.sv */
// short command queue between the front end and the glyph engine
module ctsgr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ctsgr_pkg::cmd_t  push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output ctsgr_pkg::cmd_t  head
);

    ctsgr_pkg::cmd_t entries [ctsgr_pkg::QUEUE_DEPTH];

    logic [ctsgr_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ctsgr_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ctsgr_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                           do_push, do_pop;

    assign full      = count_reg == (ctsgr_pkg::QUEUE_AW+1)'(ctsgr_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entries[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* src/ctsgr_back.sv */
// glyph engine: font memory, row fetch and one pixel write per cycle while the output is free
module ctsgr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    output logic                          q_pop,
    input  ctsgr_pkg::cmd_t               q_cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ctsgr_pkg::PIX_AW-1:0]  pixel_address,
    output logic [7:0]                    pixel_color,
    output logic                          last_pixel
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [3:0] ld_cnt_reg, ld_cnt_next;

    ctsgr_pkg::cmd_t cmd_reg;
    logic [7:0] font_mem [ctsgr_pkg::FONT_BYTES];
    logic [7:0] font_rd_reg;
    logic [7:0] rows_reg [8];
    logic [7:0] rows_clr [8];

    logic                           mem_we;
    logic [ctsgr_pkg::FONT_AW-1:0]  rd_addr;
    logic                           capture;
    logic [2:0]                     cap_idx;
    logic                           any_bits;
    logic [2:0]                     r_sel;
    logic [2:0]                     c_sel;
    logic [7:0]                     sel_row;
    logic                           slot_free;
    logic                           emit;
    logic                           is_last;
    logic [ctsgr_pkg::ROW_W-1:0]    row_idx;
    logic [ctsgr_pkg::COL_W-1:0]    col_idx;
    logic [ctsgr_pkg::LIN_W-1:0]    lin_addr;

    logic                           out_valid_reg, out_valid_next;
    logic [ctsgr_pkg::PIX_AW-1:0]   out_addr_reg;
    logic [7:0]                     out_color_reg;
    logic                           out_last_reg;

    assign out_valid     = out_valid_reg;
    assign pixel_address = out_addr_reg;
    assign pixel_color   = out_color_reg;
    assign last_pixel    = out_last_reg;

    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;
    assign mem_we    = q_pop && (q_cmd.kind == ctsgr_pkg::CMD_FONT);
    assign rd_addr   = cmd_reg.addr + ctsgr_pkg::FONT_AW'(ld_cnt_reg[2:0]);
    assign capture   = (state_reg == ST_LOAD) && (ld_cnt_reg != 4'd0);
    assign cap_idx   = 3'(ld_cnt_reg - 4'd1);
    assign slot_free = !out_valid_reg || out_ready;

    // pick the next set bit: topmost row first, leftmost pixel first
    always_comb
    begin
        any_bits = 1'b0;
        r_sel    = 3'd0;
        for (int r = 7; r >= 0; r--)
        begin
            if (rows_reg[r] != 8'd0)
            begin
                any_bits = 1'b1;
                r_sel    = 3'(r);
            end
        end
        sel_row = rows_reg[r_sel];
        c_sel   = 3'd0;
        for (int c = 7; c >= 0; c--)
        begin
            if (sel_row[7-c])
                c_sel = 3'(c);
        end
        for (int r = 0; r < 8; r++)
            rows_clr[r] = rows_reg[r];
        rows_clr[r_sel][3'd7 - c_sel] = 1'b0;
        is_last = 1'b1;
        for (int r = 0; r < 8; r++)
        begin
            if (rows_clr[r] != 8'd0)
                is_last = 1'b0;
        end
    end

    // framebuffer address of the selected pixel
    always_comb
    begin
        row_idx  = cmd_reg.y_low + ctsgr_pkg::ROW_W'(r_sel);
        col_idx  = cmd_reg.x_low + ctsgr_pkg::COL_W'(c_sel);
        lin_addr = ctsgr_pkg::LIN_W'(row_idx) * ctsgr_pkg::LIN_W'(ctsgr_pkg::SCREEN_WIDTH)
                 + ctsgr_pkg::LIN_W'(col_idx);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        ld_cnt_next = ld_cnt_reg;
        emit        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ld_cnt_next = 4'd0;
                if (q_pop && (q_cmd.kind == ctsgr_pkg::CMD_GLYPH))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                ld_cnt_next = ld_cnt_reg + 4'd1;
                if (ld_cnt_reg == 4'd8)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!any_bits)
                    state_next = ST_IDLE;
                else if (slot_free)
                begin
                    emit = 1'b1;
                    if (is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ld_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ld_cnt_reg    <= ld_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // font memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            font_mem[q_cmd.addr] <= q_cmd.data;
        font_rd_reg <= font_mem[rd_addr];
    end

    // command, row buffer and output beat
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_cmd;
        if (capture)
            rows_reg[cap_idx] <= font_rd_reg & cmd_reg.col_mask
                               & {8{cmd_reg.row_mask[cap_idx]}};
        else if (emit)
            rows_reg <= rows_clr;
        if (emit)
        begin
            out_addr_reg  <= ctsgr_pkg::PIX_AW'(lin_addr);
            out_color_reg <= cmd_reg.color;
            out_last_reg  <= is_last;
        end
    end

endmodule

/* verif/coded_text_stream_glyph_renderer_tb.sv */
// self-checking testbench for the text stream glyph renderer
module coded_text_stream_glyph_renderer_tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int OFFSET_MAX    = 16'hFFFF;

    typedef struct {
        logic [15:0] addr;
        logic [7:0]  color;
        logic        last;
    } pixel_write_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ctsgr_pkg::CFG_IW-1:0]  cfg_index;
    logic [ctsgr_pkg::CFG_DW-1:0]  cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          operation;
    logic [11:0]                   font_address;
    logic [7:0]                    font_byte;
    logic [7:0]                    stream_byte;
    logic                          last_byte;
    logic                          out_valid;
    logic                          out_ready;
    logic [15:0]                   pixel_address;
    logic [7:0]                    pixel_color;
    logic                          last_pixel;

    // expected pixel writes, oldest first
    pixel_write_t pending_pixels[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           idle_enable = 1'b1;

    // renderer state as the testbench sees it
    logic [7:0] glyph_rom [ctsgr_pkg::FONT_BYTES];
    bit         rom_loaded [ctsgr_pkg::FONT_BYTES];
    int         cursor_col;
    int         cursor_row;
    bit         color_override;
    logic [2:0] override_value;
    bit         halted;

    // configuration copy
    int         org_x;
    int         org_y;
    logic [7:0] start_color;
    int         glyph_ofs;
    int         font_limit;

    coded_text_stream_glyph_renderer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .font_address  (font_address),
        .font_byte     (font_byte),
        .stream_byte   (stream_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver with random stall bursts
    initial
    begin : sink_stalls
        int hold;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 5);
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // compare each output beat with the oldest expected pixel write
    always @(posedge clk)
    begin : check_pixels
        pixel_write_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: pixel write with none expected: addr=%0d color=%0d last=%0b",
                         $time, pixel_address, pixel_color, last_pixel);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_address !== want.addr || pixel_color !== want.color ||
                    last_pixel !== want.last)
                begin
                    $display("%0t: expected addr=%0d color=%0d last=%0b,",
                             $time, want.addr, want.color, want.last,
                             " got addr=%0d color=%0d last=%0b",
                             pixel_address, pixel_color, last_pixel);
                    mismatches++;
                end
            end
        end
    end

    function automatic int step_offset(input int v);
        return (v + 8 > OFFSET_MAX) ? OFFSET_MAX : v + 8;
    endfunction

    // true when this byte will draw a glyph; rom_at gets the address of its first font byte
    function automatic bit glyph_drawn(input logic [7:0] b, output int rom_at);
        int bound;
        rom_at = glyph_ofs + (int'(b) - int'(ctsgr_pkg::CODE_FIRST)) * 8;
        bound  = (font_limit < ctsgr_pkg::FONT_BYTES) ? font_limit : ctsgr_pkg::FONT_BYTES;
        return !halted && b != ctsgr_pkg::CODE_END && b != ctsgr_pkg::CODE_NEWLINE &&
               !b[ctsgr_pkg::COLOR_BIT] && b >= ctsgr_pkg::CODE_FIRST && rom_at + 8 <= bound;
    endfunction

    // expected pixel writes of one glyph at the cursor, clipped to the screen
    function automatic void render_glyph(input int rom_at, input logic [7:0] color);
        pixel_write_t glyph_px[$];
        pixel_write_t pix;
        int x0;
        int y0;
        int px;
        int py;
        x0 = org_x + cursor_col;
        y0 = org_y + cursor_row;
        for (int r = 0; r < 8; r++)
        begin
            py = y0 + r;
            if (py < 0 || py >= ctsgr_pkg::SCREEN_HEIGHT)
                continue;
            for (int c = 0; c < 8; c++)
            begin
                px = x0 + c;
                if (px < 0 || px >= ctsgr_pkg::SCREEN_WIDTH)
                    continue;
                if (glyph_rom[rom_at + r][7 - c])
                begin
                    pix.addr  = 16'(py * ctsgr_pkg::SCREEN_WIDTH + px);
                    pix.color = color;
                    pix.last  = 1'b0;
                    glyph_px.push_back(pix);
                end
            end
        end
        if (glyph_px.size() > 0)
            glyph_px[glyph_px.size() - 1].last = 1'b1;
        foreach (glyph_px[i])
            pending_pixels.push_back(glyph_px[i]);
    endfunction

    // expected pixels, cursor and colour update for one stream byte
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        int         rom_at;
        logic [7:0] color;
        color = color_override ? {5'd0, override_value} : start_color;
        if (glyph_drawn(b, rom_at))
            render_glyph(rom_at, color);
        if (!halted)
        begin
            if (b == ctsgr_pkg::CODE_END)
                halted = 1'b1;
            else if (b == ctsgr_pkg::CODE_NEWLINE)
            begin
                cursor_col = 0;
                cursor_row = step_offset(cursor_row);
            end
            else if (b[ctsgr_pkg::COLOR_BIT])
            begin
                override_value = b[2:0];
                color_override = 1'b1;
            end
            else
                cursor_col = step_offset(cursor_col);
        end
        if (last)
        begin
            cursor_col     = 0;
            cursor_row     = 0;
            color_override = 1'b0;
            override_value = 3'd0;
            halted         = 1'b0;
        end
    endfunction

    // one input beat, with an optional idle burst in front
    task automatic send_beat(input logic op, input logic [11:0] addr, input logic [7:0] fdata,
                             input logic [7:0] sbyte, input logic last);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        font_address <= addr;
        font_byte    <= fdata;
        stream_byte  <= sbyte;
        last_byte    <= last;
        if (op == ctsgr_pkg::OP_FONT)
        begin
            glyph_rom[addr]  = fdata;
            rom_loaded[addr] = 1'b1;
        end
        else
            predict_byte(sbyte, last);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic load_font(input logic [11:0] addr, input logic [7:0] data);
        send_beat(ctsgr_pkg::OP_FONT, addr, data, 8'($urandom), 1'($urandom));
    endtask

    // stream byte; font rows of the glyph it draws are loaded first if still empty
    task automatic feed_byte(input logic [7:0] b, input logic last);
        int rom_at;
        if (glyph_drawn(b, rom_at))
            for (int r = 0; r < 8; r++)
                if (!rom_loaded[rom_at + r])
                    load_font(12'(rom_at + r), 8'($urandom));
        send_beat(ctsgr_pkg::OP_STREAM, 12'($urandom), 8'($urandom), b, last);
    endtask

    // stop sending and let the block run dry
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ctsgr_pkg::CFG_IW-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ctsgr_pkg::CFG_DW'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // full register set, written only once the block is idle
    task automatic set_regs(input int ox, input int oy, input logic [7:0] color,
                            input int base, input int size);
        settle();
        write_reg(ctsgr_pkg::REG_ORIGIN_X, ox & 'h7FF);
        write_reg(ctsgr_pkg::REG_ORIGIN_Y, oy & 'h7FF);
        write_reg(ctsgr_pkg::REG_INITIAL_COLOR, int'(color));
        write_reg(ctsgr_pkg::REG_GLYPH_BASE, base);
        write_reg(ctsgr_pkg::REG_FONT_SIZE, size);
        cfg_valid <= 1'b0;
        org_x       = ox;
        org_y       = oy;
        start_color = color;
        glyph_ofs   = base;
        font_limit  = size;
    endtask

    // font extremes, every control code, colour, end of stream and last byte
    task automatic test_stream_codes();
        set_regs(0, 0, 8'hA5, 0, ctsgr_pkg::FONT_BYTES);
        load_font(12'hFFF, 8'h81);
        for (int i = 0; i < 8; i++)
            load_font(12'(i), 8'hFF);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b0);
        feed_byte(8'h1F, 1'b0);
        feed_byte(8'h7F, 1'b0);
        feed_byte(ctsgr_pkg::CODE_NEWLINE, 1'b0);
        feed_byte(8'h85, 1'b0);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b0);
        feed_byte(8'h80, 1'b0);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b0);
        feed_byte(ctsgr_pkg::CODE_END, 1'b0);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b0);
        feed_byte(ctsgr_pkg::CODE_NEWLINE, 1'b1);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b1);
        feed_byte(8'h00, 1'b0);
        feed_byte(ctsgr_pkg::CODE_END, 1'b1);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b0);
    endtask

    // glyphs partly or wholly off each screen edge
    task automatic test_clipping();
        set_regs(-4, -3, 8'h00, 0, ctsgr_pkg::FONT_BYTES);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b1);
        set_regs(ctsgr_pkg::SCREEN_WIDTH - 4, ctsgr_pkg::SCREEN_HEIGHT - 4, 8'hFF, 0,
                 ctsgr_pkg::FONT_BYTES);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b0);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b0);
        feed_byte(ctsgr_pkg::CODE_NEWLINE, 1'b0);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b1);
        set_regs(-1024, -1024, 8'h5A, 0, ctsgr_pkg::FONT_BYTES);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b1);
        set_regs(1023, 1023, 8'h3C, 0, ctsgr_pkg::FONT_BYTES);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b1);
    endtask

    // glyphs ending at, and past, the font size
    task automatic test_font_bound();
        set_regs(8, 8, 8'h11, 12'hFFF, ctsgr_pkg::FONT_BYTES);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b1);
        set_regs(0, 0, 8'h22, 16, 32);
        feed_byte(8'h20, 1'b0);
        feed_byte(8'h21, 1'b0);
        feed_byte(8'h22, 1'b1);
        set_regs(0, 0, 8'h33, 0, 0);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b1);
    endtask

    // runs of non-drawing bytes and new lines carry the cursor from off screen into view
    task automatic test_cursor_runs();
        set_regs(-100, -60, 8'h44, 0, ctsgr_pkg::FONT_BYTES);
        repeat (8) feed_byte(ctsgr_pkg::CODE_NEWLINE, 1'b0);
        repeat (14) feed_byte(8'h01, 1'b0);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b0);
        feed_byte(ctsgr_pkg::CODE_FIRST, 1'b1);
    endtask

    // printable bytes come from a small spread-out set so few glyphs need loading
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            return 8'(32 + 12 * $urandom_range(0, 7));
        else if (pick < 88)
            return ctsgr_pkg::CODE_NEWLINE;
        else if (pick < 95)
            return 8'h80 | 8'($urandom_range(0, 126));
        else if (pick < 98)
            return 8'($urandom_range(0, 31));
        return ctsgr_pkg::CODE_END;
    endfunction

    // random lines of text under random settings, with font writes and stray bytes
    task automatic test_random_streams();
        int fed;
        int len;
        int pick;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
                idle_enable = 1'b0;
            set_regs(($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2047)) - 1024
                                                 : int'($urandom_range(0, 340)) - 16,
                     ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2047)) - 1024
                                                 : int'($urandom_range(0, 220)) - 16,
                     8'($urandom),
                     ($urandom_range(0, 3) != 0) ? 0 : int'($urandom_range(0, 3400)),
                     ($urandom_range(0, 9) < 7) ? ctsgr_pkg::FONT_BYTES
                                                : int'($urandom_range(0, ctsgr_pkg::FONT_BYTES)));
            fed = 0;
            while (fed < 32)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    len = $urandom_range(3, 12);
                    for (int k = 0; k < len; k++)
                        feed_byte(text_byte(), k == len - 1);
                    fed += len;
                end
                else if (pick == 8)
                    load_font(12'($urandom), 8'($urandom));
                else
                begin
                    feed_byte(8'($urandom), 1'($urandom));
                    fed++;
                end
            end
        end
    endtask

    // reset, test sequence and final verdict
    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = ctsgr_pkg::OP_FONT;
        font_address = '0;
        font_byte    = '0;
        stream_byte  = '0;
        last_byte    = 1'b0;
        cursor_col     = 0;
        cursor_row     = 0;
        color_override = 1'b0;
        override_value = 3'd0;
        halted         = 1'b0;
        org_x       = 0;
        org_y       = 0;
        start_color = 8'd0;
        glyph_ofs   = 0;
        font_limit  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_stream_codes();
        test_clipping();
        test_font_bound();
        test_cursor_runs();
        test_random_streams();
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
src/ctsgr_pkg.sv
src/ctsgr_front.sv
src/ctsgr_queue.sv
src/ctsgr_back.sv
src/coded_text_stream_glyph_renderer.sv
verif/coded_text_stream_glyph_renderer_tb.sv
